// ===== src/modular_exponentiation_encrypt_unit_macros.svh =====
// Assertion macros shared by the modular exponentiation encrypt unit.
`ifndef MODULAR_EXPONENTIATION_ENCRYPT_UNIT_MACROS_SVH
`define MODULAR_EXPONENTIATION_ENCRYPT_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MEE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MEE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mee_pkg.sv =====
// Shared constants and the modular multiply step for the modular exponentiation encrypt unit.
package mee_pkg;

  localparam int DATA_W        = 31;
  localparam int MSG_W         = 8;
  localparam int CFG_IDX_W     = 1;
  localparam int STEP_W        = $clog2(DATA_W + 1);
  localparam int WIDTH_DEFAULT = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPONENT = 1'b1;

  localparam logic [DATA_W-1:0] MODULUS_RESET  = 31'd3233;
  localparam logic [DATA_W-1:0] EXPONENT_RESET = 31'd17;
  localparam logic [DATA_W-1:0] MODULUS_MIN    = 31'd2;

  // One step of interleaved modular multiplication: (2r + bit*a) mod n.
  // With r < n and a < n the sum stays below 3n, so at most one subtraction, of n or 2n.
  function automatic logic [DATA_W-1:0] modmul_step(input logic [DATA_W-1:0] r,
                                                    input logic [DATA_W-1:0] a,
                                                    input logic              b_bit,
                                                    input logic [DATA_W-1:0] n);
    logic [DATA_W+1:0] t;
    logic [DATA_W+1:0] n1;
    logic [DATA_W+1:0] n2;
    t  = {1'b0, r, 1'b0} + {2'b00, (a & {DATA_W{b_bit}})};
    n1 = {2'b00, n};
    n2 = {1'b0, n, 1'b0};
    priority if (t >= n2) begin
      t = t - n2;
    end else if (t >= n1) begin
      t = t - n1;
    end else begin
      t = t;
    end
    return t[DATA_W-1:0];
  endfunction

endpackage

// ===== src/modular_exponentiation_encrypt_unit.sv =====
// Top level of the modular exponentiation encrypt unit (RSA c = m^e mod n per character).
//
// Each request carries one character code and a last-character flag; the unit returns
// one ciphertext value m^e mod n with the flag copied through. Modulus n (index 0) and
// public exponent e (index 1) are written through the cfg port; the user must write
// them only while the unit is idle, as the unit does not enforce this. They reset to
// 3233 and 17. The exponent is scanned MSB first over WIDTH bits; bits of e at and
// above WIDTH are ignored. A modulus below two gives 0. All arithmetic runs through
// one shared modular multiply-step unit that retires one multiplier bit per cycle.
// msg_ready is high only while no request is in work; a finished ciphertext waits in
// the output register, so the next request can start before it is taken.
`include "modular_exponentiation_encrypt_unit_macros.svh"

module modular_exponentiation_encrypt_unit #(
  parameter int WIDTH = mee_pkg::WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mee_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mee_pkg::DATA_W-1:0]       cfg_data,
  // message request channel
  input  logic                             msg_valid,
  output logic                             msg_ready,
  input  logic [mee_pkg::MSG_W-1:0]        message_char,
  input  logic                             last_char,
  // ciphertext channel
  output logic                             cipher_valid,
  input  logic                             cipher_ready,
  output logic [mee_pkg::DATA_W-1:0]       cipher_value,
  output logic                             last_out
);

  localparam int DATA_W    = mee_pkg::DATA_W;
  localparam int MSG_W     = mee_pkg::MSG_W;
  localparam int STEP_W    = mee_pkg::STEP_W;
  localparam int EXP_CNT_W = $clog2(WIDTH + 1);

  // Sequencer: reduce the base, then per exponent bit a square and maybe a multiply.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_REDUCE = 5'b00010,
    S_SQUARE = 5'b00100,
    S_MULT   = 5'b01000,
    S_HOLD   = 5'b10000
  } state_t;

  state_t                 state;

  logic [DATA_W-1:0]      modulus;
  logic [DATA_W-1:0]      public_exponent;

  logic [DATA_W-1:0]      acc;        // running power, also the finished result
  logic [DATA_W-1:0]      base;       // m mod n
  logic [DATA_W-1:0]      mul_a;      // multiplicand, always below n
  logic [DATA_W-1:0]      mul_b;      // multiplier, scanned MSB first
  logic [DATA_W-1:0]      mul_r;      // partial product mod n
  logic [STEP_W-1:0]      step_cnt;   // multiplier bits left
  logic [WIDTH-1:0]       exp_sh;     // exponent bits, MSB is the current one
  logic [EXP_CNT_W-1:0]   exp_cnt;    // exponent bits left, current one included
  logic                   last_q;

  logic [DATA_W-1:0]      mul_next;
  logic                   mul_done;
  logic                   last_bit;
  logic                   small_mod;
  logic                   msg_accept;
  logic                   out_free;

  assign cfg_ready  = 1'b1;
  assign msg_ready  = (state == S_IDLE);
  assign msg_accept = msg_valid && msg_ready;
  assign out_free   = !cipher_valid || cipher_ready;

  assign mul_next  = mee_pkg::modmul_step(mul_r, mul_a, mul_b[DATA_W-1], modulus);
  assign mul_done  = (step_cnt == STEP_W'(1));
  assign last_bit  = (exp_cnt == EXP_CNT_W'(1));
  assign small_mod = (modulus < mee_pkg::MODULUS_MIN);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus         <= mee_pkg::MODULUS_RESET;
      public_exponent <= mee_pkg::EXPONENT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == mee_pkg::REG_MODULUS) begin
        modulus <= cfg_data;
      end else if (cfg_index == mee_pkg::REG_EXPONENT) begin
        public_exponent <= cfg_data;
      end
    end
  end

  // Control: sequencer state and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cipher_valid <= 1'b0;
    end else begin
      // a new result may load in the same cycle the old one is taken
      if (state == S_HOLD && out_free) begin
        cipher_valid <= 1'b1;
      end else if (cipher_valid && cipher_ready) begin
        cipher_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (msg_valid) begin
            state <= small_mod ? S_HOLD : S_REDUCE;
          end
        end
        S_REDUCE: begin
          if (mul_done) begin
            state <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          if (mul_done) begin
            if (exp_sh[WIDTH-1]) begin
              state <= S_MULT;
            end else if (last_bit) begin
              state <= S_HOLD;
            end
          end
        end
        S_MULT: begin
          if (mul_done) begin
            state <= last_bit ? S_HOLD : S_SQUARE;
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath: operand loading, multiply steps, exponent scan, result register.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (msg_accept) begin
          acc      <= small_mod ? '0 : DATA_W'(1);
          last_q   <= last_char;
          exp_sh   <= WIDTH'(public_exponent);
          exp_cnt  <= EXP_CNT_W'(WIDTH);
          // m mod n as 1 * m, scanning the eight bits of m
          mul_a    <= DATA_W'(1);
          mul_b    <= {message_char, {(DATA_W - MSG_W){1'b0}}};
          mul_r    <= '0;
          step_cnt <= STEP_W'(MSG_W);
        end
      end
      S_REDUCE, S_SQUARE, S_MULT: begin
        if (mul_done) begin
          mul_r    <= '0;
          step_cnt <= STEP_W'(DATA_W);
          if (state == S_REDUCE) begin
            base  <= mul_next;
            mul_a <= acc;
            mul_b <= acc;
          end else if (state == S_SQUARE && exp_sh[WIDTH-1]) begin
            acc   <= mul_next;
            mul_a <= mul_next;
            mul_b <= base;
          end else begin
            // square with a clear bit, or multiply: move to the next exponent bit
            acc     <= mul_next;
            mul_a   <= mul_next;
            mul_b   <= mul_next;
            exp_sh  <= exp_sh << 1;
            exp_cnt <= exp_cnt - EXP_CNT_W'(1);
          end
        end else begin
          mul_r    <= mul_next;
          mul_b    <= mul_b << 1;
          step_cnt <= step_cnt - STEP_W'(1);
        end
      end
      S_HOLD: begin
        if (out_free) begin
          cipher_value <= acc;
          last_out     <= last_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Residues stay reduced while a multiply is running.
  `MEE_ASSERT_NOW(a_acc_reduced, (state == S_SQUARE || state == S_MULT), (acc < modulus), "accumulator not below modulus")
  `MEE_ASSERT_NOW(a_partial_reduced, (state == S_REDUCE || state == S_SQUARE || state == S_MULT), (mul_r < modulus && mul_a < modulus), "multiply operand or partial not below modulus")
  `MEE_ASSERT_NOW(a_exp_left, (state == S_SQUARE || state == S_MULT), (exp_cnt != '0 && step_cnt != '0), "exponent or step counter ran out while busy")
  `MEE_ASSERT_NEXT(a_start, msg_accept, (state != S_IDLE), "accepted request did not start work")

endmodule
